// File: src/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // Sizes
    localparam int NUM_LEVELS = 5;
    localparam int LEVEL_W    = 3;
    localparam int SLICE_W    = 6;
    localparam int SAMPLE_W   = 10;
    localparam int LED_W      = 8;
    localparam int BCD_W      = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = $clog2(NUM_LEVELS * 4);

    // Potentiometer level thresholds: level = sample / LEVEL_DIV, clamped at 4
    localparam int LEVEL_DIV = 205;
    localparam logic [SAMPLE_W-1:0] LEVEL1_MIN = SAMPLE_W'(LEVEL_DIV * 1);
    localparam logic [SAMPLE_W-1:0] LEVEL2_MIN = SAMPLE_W'(LEVEL_DIV * 2);
    localparam logic [SAMPLE_W-1:0] LEVEL3_MIN = SAMPLE_W'(LEVEL_DIV * 3);
    localparam logic [SAMPLE_W-1:0] LEVEL4_MIN = SAMPLE_W'(LEVEL_DIV * 4);

    // Step constants
    localparam logic [LED_W-1:0] BOUNCE_RIGHT_END = 8'h07;
    localparam logic [LED_W-1:0] BOUNCE_LEFT_END  = 8'hE0;
    localparam logic [BCD_W-1:0] BCD_MAX          = 4'd9;

    // Mode codes
    localparam logic MODE_BCD    = 1'b0;
    localparam logic MODE_BOUNCE = 1'b1;

    // Register indexes
    typedef enum logic [LEVEL_W-1:0] {
        REG_LEVEL0 = 3'd0,
        REG_LEVEL1 = 3'd1,
        REG_LEVEL2 = 3'd2,
        REG_LEVEL3 = 3'd3,
        REG_LEVEL4 = 3'd4
    } t_reg_idx;

    typedef logic [SLICE_W-1:0]               t_slices;
    typedef t_slices [NUM_LEVELS-1:0]         t_slice_tbl;

    localparam t_slice_tbl SLICES_RST = {6'd5, 6'd10, 6'd20, 6'd30, 6'd50};

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                adc_valid;
        logic                next_button;
        logic                prev_button;
    } t_req;

    typedef struct packed {
        logic [LED_W-1:0] led_pattern;
        logic             pattern_updated;
        logic             mode;
    } t_rsp;

    typedef struct packed {
        t_slices          slice_idx;
        t_slices          period;
        logic [BCD_W-1:0] bcd_units;
        logic [BCD_W-1:0] bcd_tens;
        logic [LED_W-1:0] bounce;
    } t_core_status;

    // Map a sample to its speed level by threshold compares
    function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] sample);
        logic [LEVEL_W-1:0] lvl;
        if (sample >= LEVEL4_MIN) begin
            lvl = 3'd4;
        end else if (sample >= LEVEL3_MIN) begin
            lvl = 3'd3;
        end else if (sample >= LEVEL2_MIN) begin
            lvl = 3'd2;
        end else if (sample >= LEVEL1_MIN) begin
            lvl = 3'd1;
        end else begin
            lvl = 3'd0;
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

// File: src/lps_if.sv
`default_nettype none

interface lps_req_if
    import lps_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lps_rsp_if
    import lps_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/led_pattern_sequencer_top.sv
// Channel  | Dir | Payload                                          | Handshake
// ---------+-----+--------------------------------------------------+-------------
// i_req    | in  | adc_sample[9:0], adc_valid, next_button, prev_b. | valid/ready
// o_rsp    | out | led_pattern[7:0], pattern_updated, mode          | valid/ready
// APB      | in  | paddr[4:0], pwdata[31:0] -> prdata[31:0]         | psel/penable
//
// One request per cycle sustained while results are taken; each request yields one
// result after acceptance (input register, then result register).
// The whole slice update is a single combinational pass between those registers.
// Reset is synchronous, active low; no clearing pass, ready is low during reset
// and rises as soon as reset is released.
// A stalled result register blocks the input register; the input side still
// takes a request in the cycle the result is taken.
`default_nettype none

module led_pattern_sequencer_top
    import lps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lps_req_if.sink                    i_req,
    lps_rsp_if.source                  o_rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_slice_tbl   w_slices;
    t_core_status w_status;

    lps_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_slices (w_slices)
    );

    lps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_slices (w_slices),
        .o_status (w_status)
    );

    // Slice counter stays inside the current period
    a_slice_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.slice_idx == '0) || (w_status.slice_idx < w_status.period))
        else $error("slice index past period length");

    // Counter digits stay decimal
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.bcd_units <= BCD_MAX) && (w_status.bcd_tens <= BCD_MAX))
        else $error("BCD digit out of range");

    // Bouncing block always has three lit LEDs
    a_bounce_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_status.bounce) == 3)
        else $error("bounce block lost its width");

    // No period length set until a step has happened
    a_period_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.period == '0) |-> (w_status.slice_idx == '0))
        else $error("counting slices without a period");

endmodule

`default_nettype wire

// File: src/lps_cfg_regs.sv
`default_nettype none

module lps_cfg_regs
    import lps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_slice_tbl                 o_slices
);

    t_slice_tbl         r_slices;
    logic [LEVEL_W-1:0] w_idx;
    logic               w_hit;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_hit  = (w_idx <= REG_LEVEL4);
    assign w_wr   = psel && penable && pwrite && pready;

    // Write slice counts; addresses past the last register drop the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slices <= SLICES_RST;
        end else if (w_wr && w_hit) begin
            r_slices[w_idx] <= pwdata[SLICE_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = APB_DATA_W'(r_slices[w_idx]);
        end
    end

    assign o_slices = r_slices;

endmodule

`default_nettype wire

// File: src/lps_core.sv
`default_nettype none

module lps_core
    import lps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lps_req_if.sink    i_req,
    lps_rsp_if.source  o_rsp,
    input  wire t_slice_tbl i_slices,
    output t_core_status o_status
);

    // Input and result stages
    logic r_in_vld;
    t_req r_in;
    logic r_out_vld;
    t_rsp r_out;
    t_rsp n_rsp;

    // Sequencer state
    logic             r_mode,      n_mode;
    logic [BCD_W-1:0] r_units,     n_units;
    logic [BCD_W-1:0] r_tens,      n_tens;
    logic [LED_W-1:0] r_bounce,    n_bounce;
    logic             r_left,      n_left;
    logic             r_last_next, n_last_next;
    logic             r_last_prev, n_last_prev;
    t_slices          r_slice_idx, n_slice_idx;
    t_slices          r_period,    n_period;
    logic [LED_W-1:0] r_shown,     n_shown;

    logic               w_adv;
    logic               w_take;
    logic               w_start;
    logic               w_step;
    logic               w_run;
    logic [LEVEL_W-1:0] w_level;
    t_slices            w_cfg_n;
    logic [SLICE_W:0]   w_idx_inc;

    // Handshake: result stage frees when empty or taken; hold off requests in reset
    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign w_take      = r_in_vld && w_adv;
    assign i_req.ready = i_rst_n && (!r_in_vld || w_adv);

    // Hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    // Period start decode and speed lookup
    assign w_start = (r_slice_idx == '0);
    assign w_step  = w_start && r_in.adc_valid;
    assign w_run   = !w_start || r_in.adc_valid;
    assign w_level = level_of(r_in.adc_sample);
    always_comb begin
        w_cfg_n = i_slices[w_level];
        if (w_cfg_n == '0) begin
            w_cfg_n = t_slices'(1);
        end
    end

    // Next state for one slice
    always_comb begin
        n_mode      = r_mode;
        n_units     = r_units;
        n_tens      = r_tens;
        n_bounce    = r_bounce;
        n_left      = r_left;
        n_last_next = r_last_next;
        n_last_prev = r_last_prev;
        n_slice_idx = r_slice_idx;
        n_period    = r_period;
        n_shown     = r_shown;
        w_idx_inc   = {1'b0, r_slice_idx} + 1'b1;

        // Advance the active pattern at a period start
        if (w_step) begin
            n_period = w_cfg_n;
            if (r_mode == MODE_BCD) begin
                n_shown = {r_tens, r_units};
                if (r_units >= BCD_MAX) begin
                    n_units = '0;
                    n_tens  = (r_tens >= BCD_MAX) ? '0 : r_tens + 1'b1;
                end else begin
                    n_units = r_units + 1'b1;
                end
            end else begin
                n_shown = r_bounce;
                if (r_left) begin
                    n_bounce = {r_bounce[LED_W-2:0], 1'b0};
                    if (n_bounce == BOUNCE_LEFT_END) begin
                        n_left = 1'b0;
                    end
                end else begin
                    n_bounce = {1'b0, r_bounce[LED_W-1:1]};
                    if (n_bounce == BOUNCE_RIGHT_END) begin
                        n_left = 1'b1;
                    end
                end
            end
        end

        // Poll buttons and count slices
        if (w_run) begin
            n_mode = r_mode
                   ^ (r_last_next && !r_in.next_button)
                   ^ (r_last_prev && !r_in.prev_button);
            n_last_next = r_in.next_button;
            n_last_prev = r_in.prev_button;
            if (w_idx_inc >= {1'b0, n_period}) begin
                n_slice_idx = '0;
            end else begin
                n_slice_idx = w_idx_inc[SLICE_W-1:0];
            end
        end

        n_rsp.led_pattern     = n_shown;
        n_rsp.pattern_updated = w_step;
        n_rsp.mode            = n_mode;
    end

    // Commit state when the request moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BCD;
            r_units     <= '0;
            r_tens      <= '0;
            r_bounce    <= BOUNCE_RIGHT_END;
            r_left      <= 1'b1;
            r_last_next <= 1'b1;
            r_last_prev <= 1'b1;
            r_slice_idx <= '0;
            r_period    <= '0;
            r_shown     <= '0;
        end else if (w_take) begin
            r_mode      <= n_mode;
            r_units     <= n_units;
            r_tens      <= n_tens;
            r_bounce    <= n_bounce;
            r_left      <= n_left;
            r_last_next <= n_last_next;
            r_last_prev <= n_last_prev;
            r_slice_idx <= n_slice_idx;
            r_period    <= n_period;
            r_shown     <= n_shown;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    assign o_status.slice_idx = r_slice_idx;
    assign o_status.period    = r_period;
    assign o_status.bcd_units = r_units;
    assign o_status.bcd_tens  = r_tens;
    assign o_status.bounce    = r_bounce;

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
    import lps_pkg::*;

    localparam int REG_STRIDE      = 4;
    localparam int SPARE_REG       = NUM_LEVELS;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int DRAIN_CYCLES    = 4;
    localparam int QUIET_LIMIT     = 2000;

    // Predict one LED result per slice request and hold the expected results in order
    class pattern_scoreboard;
        t_slices          slices_per_level [NUM_LEVELS];
        logic             mode;
        logic [BCD_W-1:0] units;
        logic [BCD_W-1:0] tens;
        logic [LED_W-1:0] block;
        logic             block_left;
        logic             last_next;
        logic             last_prev;
        t_slices          slice_pos;
        t_slices          period_len;
        logic [LED_W-1:0] shown;
        t_rsp             expected_leds [$];
        int errors;
        int slices_seen;
        int bcd_steps;
        int bcd_wraps;
        int bounce_steps;
        int skipped_starts;
        int mode_flips;

        function new();
            for (int i = 0; i < NUM_LEVELS; i++) begin
                slices_per_level[i] = SLICES_RST[i];
            end
            mode       = MODE_BCD;
            units      = '0;
            tens       = '0;
            block      = BOUNCE_RIGHT_END;
            block_left = 1'b1;
            last_next  = 1'b1;
            last_prev  = 1'b1;
            slice_pos  = '0;
            period_len = '0;
            shown      = '0;
        endfunction

        // Show tens:units, then count up and wrap at 99
        function void advance_counter();
            shown = {tens, units};
            units = units + 1'b1;
            if (units > BCD_MAX) begin
                units = '0;
                tens  = tens + 1'b1;
                if (tens > BCD_MAX) begin
                    tens = '0;
                    bcd_wraps++;
                end
            end
            bcd_steps++;
        endfunction

        // Show the block, then shift it and reverse at either end
        function void advance_block();
            shown = block;
            if (block_left) begin
                block = block << 1;
                if (block == BOUNCE_LEFT_END) block_left = 1'b0;
            end else begin
                block = block >> 1;
                if (block == BOUNCE_RIGHT_END) block_left = 1'b1;
            end
            bounce_steps++;
        endfunction

        // Note an accepted slice request and queue the result it causes
        function void take_slice(t_req req);
            t_rsp    want;
            logic    stepped;
            logic    polled;
            int      level;
            t_slices len;
            stepped = 1'b0;
            polled  = 1'b1;
            slices_seen++;
            if (slice_pos == 0) begin
                if (!req.adc_valid) begin
                    // bad sample at a period start: no step, no poll
                    polled = 1'b0;
                    skipped_starts++;
                end else begin
                    level = int'(req.adc_sample) / LEVEL_DIV;
                    if (level > NUM_LEVELS - 1) level = NUM_LEVELS - 1;
                    len = slices_per_level[level];
                    if (len == 0) len = 1;
                    period_len = len;
                    if (mode == MODE_BCD) advance_counter();
                    else advance_block();
                    stepped = 1'b1;
                end
            end
            if (polled) begin
                // each falling edge flips the mode, so two at once cancel
                if (last_next && !req.next_button) begin
                    mode = ~mode;
                    mode_flips++;
                end
                if (last_prev && !req.prev_button) begin
                    mode = ~mode;
                    mode_flips++;
                end
                last_next = req.next_button;
                last_prev = req.prev_button;
                slice_pos = slice_pos + 1'b1;
                if (slice_pos >= period_len) slice_pos = '0;
            end
            want.led_pattern     = shown;
            want.pattern_updated = stepped;
            want.mode            = mode;
            expected_leds.push_back(want);
        endfunction

        // Compare an accepted result against the oldest expectation
        function void check_led_result(t_rsp got);
            t_rsp want;
            if (expected_leds.size() == 0) begin
                $error("unexpected result: led_pattern %0h pattern_updated %0b mode %0b",
                       got.led_pattern, got.pattern_updated, got.mode);
                errors++;
                return;
            end
            want = expected_leds.pop_front();
            if (got.led_pattern !== want.led_pattern) begin
                $error("led_pattern: expected %0h, actual %0h", want.led_pattern,
                       got.led_pattern);
                errors++;
            end
            if (got.pattern_updated !== want.pattern_updated) begin
                $error("pattern_updated: expected %0b, actual %0b", want.pattern_updated,
                       got.pattern_updated);
                errors++;
            end
            if (got.mode !== want.mode) begin
                $error("mode: expected %0b, actual %0b", want.mode, got.mode);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lps_req_if req_if ();
    lps_rsp_if rsp_if ();

    pattern_scoreboard sb;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   send_calm;
    int   recv_calm;
    int   quiet_cycles;
    logic next_lvl;
    logic prev_lvl;

    // Opening slices under the reset levels: period starts, mid-period noise,
    // single and double button falls, a bad sample at a period start
    t_req directed_slices [24] = '{
        {10'd1023, 1'b1, 1'b1, 1'b1},
        {10'd0,    1'b0, 1'b0, 1'b0},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd512,  1'b1, 1'b0, 1'b1},
        {10'd300,  1'b0, 1'b1, 1'b1},
        {10'd1023, 1'b0, 1'b0, 1'b1},
        {10'd820,  1'b1, 1'b1, 1'b0},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd1023, 1'b1, 1'b0, 1'b1},
        {10'd0,    1'b0, 1'b1, 1'b1},
        {10'd0,    1'b0, 1'b1, 1'b1},
        {10'd819,  1'b1, 1'b1, 1'b1},
        {10'd1023, 1'b0, 1'b0, 1'b0},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd1023, 1'b1, 1'b1, 1'b0},
        {10'd512,  1'b0, 1'b1, 1'b1},
        {10'd0,    1'b1, 1'b0, 1'b0},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd0,    1'b1, 1'b0, 1'b1},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd0,    1'b1, 1'b1, 1'b0},
        {10'd820,  1'b1, 1'b1, 1'b1},
        {10'd0,    1'b1, 1'b1, 1'b1},
        {10'd0,    1'b1, 1'b1, 1'b1}
    };

    led_pattern_sequencer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random, with calm stretches
    always @(posedge i_clk) begin
        if (recv_calm > 0) begin
            recv_calm     <= recv_calm - 1;
            rsp_if.ready  <= 1'b1;
        end else if ($urandom_range(99) < recv_idle_pct) begin
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready  <= 1'b1;
            if ($urandom_range(63) == 0) recv_calm <= $urandom_range(40, 10);
        end
    end

    // Track accepted requests and results, count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) sb.take_slice(req_if.payload);
            if (rsp_if.valid && rsp_if.ready) sb.check_led_result(rsp_if.payload);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Abort when nothing moves for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    // Build a random slice: buttons mostly hold, samples often near level thresholds
    function automatic t_req random_slice();
        t_req item;
        int   k;
        if ($urandom_range(99) < 30) next_lvl = ~next_lvl;
        if ($urandom_range(99) < 30) prev_lvl = ~prev_lvl;
        case ($urandom_range(7))
            0: begin
                k = $urandom_range(NUM_LEVELS - 1, 1);
                item.adc_sample = SAMPLE_W'(k * LEVEL_DIV - int'($urandom_range(1)));
            end
            1: item.adc_sample = $urandom_range(1) ? '1 : '0;
            default: item.adc_sample = SAMPLE_W'($urandom_range(1023));
        endcase
        item.adc_valid   = ($urandom_range(99) < 88);
        item.next_button = next_lvl;
        item.prev_button = prev_lvl;
        return item;
    endfunction

    // Offer one slice request, idling first at random; return once it is taken
    task automatic push_slice(input t_req item);
        while (send_calm == 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(63) == 0) send_calm = $urandom_range(40, 10);
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic run_random(input int count);
        repeat (count) push_slice(random_slice());
    endtask

    // Drop the request line and wait until every result is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_leds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one slice-count register; the bus stays selected for a following write
    task automatic write_slices(input int idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < NUM_LEVELS) sb.slices_per_level[idx] = t_slices'(value);
    endtask

    task automatic load_levels(input int s0, input int s1, input int s2, input int s3,
                               input int s4);
        write_slices(REG_LEVEL0, s0);
        write_slices(REG_LEVEL1, s1);
        write_slices(REG_LEVEL2, s2);
        write_slices(REG_LEVEL3, s3);
        write_slices(REG_LEVEL4, s4);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        next_lvl       = 1'b1;
        prev_lvl       = 1'b1;
        send_calm      = 0;
        recv_calm      = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 26;
        recv_idle_pct  = 48;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset levels, directed slices, then a short random run
        foreach (directed_slices[i]) push_slice(directed_slices[i]);
        run_random(ITEMS_PER_PHASE / 2);
        wait_drained();

        // Every slice starts a period
        load_levels(1, 1, 1, 1, 1);
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        // Swap idling; longest period, and a zero count that acts as one
        send_idle_pct = 48;
        recv_idle_pct = 26;
        load_levels(63, 2, 1, 3, 0);
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        // No idling; short random periods, and a write past the last register
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_slices(SPARE_REG, 63);
        load_levels($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                    $urandom_range(8, 1), $urandom_range(8, 1));
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        if (sb.expected_leds.size() != 0) begin
            $error("%0d results never arrived", sb.expected_leds.size());
            sb.errors++;
        end
        $display("run covered %0d slices: %0d counter steps with %0d wraps, %0d block steps",
                 sb.slices_seen, sb.bcd_steps, sb.bcd_wraps, sb.bounce_steps);
        $display("%0d mode flips, %0d period starts skipped on a bad sample, %0d mismatches",
                 sb.mode_flips, sb.skipped_starts, sb.errors);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: led_pattern_sequencer_top.f
src/lps_pkg.sv
src/lps_if.sv
src/lps_cfg_regs.sv
src/lps_core.sv
src/led_pattern_sequencer_top.sv
dv/testbench.sv
